// File: hdl/assert_macros.svh
// assertion helpers for the rtl files, included by led_matrix_pixel_framebuffer_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hdl/lmpf_pkg.sv
// ----------------------------------------------------------------------------
// lmpf_pkg
// types and constants of the led matrix pixel frame buffer
// ----------------------------------------------------------------------------
package lmpf_pkg;

   localparam int unsigned LANE_W     = 16;
   localparam int unsigned NUM_BANDS  = 8;
   localparam int unsigned PLANES     = 3;
   localparam int unsigned BANK_DEPTH = 512;
   localparam int unsigned BANK_AW    = 9;
   localparam int unsigned CSR_IDX_W  = 4;

   // opcodes
   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_GET  = 2'd1;
   localparam logic [1:0] OP_SCAN = 2'd2;

   // lane mask reset values, band 7 first
   localparam logic [NUM_BANDS-1:0][LANE_W-1:0] BAND_RESET = {
      16'h0010, 16'h8000, 16'h0008, 16'h0020,
      16'h0100, 16'h0040, 16'h0080, 16'h0200
   };

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] pixel_x;
      logic [5:0] pixel_y;
      logic [2:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [2:0]        read_color;
      logic [LANE_W-1:0] scan_word;
      logic [1:0]        row_address;
      logic              last_in_row;
   } rsp_type;

   // item held while its bank read completes
   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         color;
      logic [2:0]         band;
      logic [BANK_AW-1:0] addr;
      logic [1:0]         plane;
      logic [1:0]         row;
      logic               last;
   } stage_type;

endpackage

// File: hdl/led_matrix_pixel_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_pixel_framebuffer_unit
// 64x64 rgb frame store in 1/4-scan panel word order, with set, get and scan
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  req_      in    req_valid/req_stall  opcode, pixel_x, pixel_y, pixel_color
//  rsp_      out   rsp_valid/rsp_stall  read_color, scan_word, row_address,
//                                       last_in_row
//  csr_      in    csr_valid/csr_ready  csr_index, csr_wdata (band masks)
//
//  one item per cycle sustained while rsp_stall is low and no clearing pass runs;
//  the bank read loads rd_ff at the accepting edge, then the modify, write back
//  and result register load happen when the item advances out of s1_ff
//  after reset a clearing pass zeroes the three plane banks,
//  req_stall is high for its length; csr writes are taken throughout
//  rsp_stall holds the result register and the item behind it, which
//  stalls req_
//
`include "assert_macros.svh"

module led_matrix_pixel_framebuffer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lmpf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lmpf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lmpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lmpf_pkg::LANE_W-1:0]          csr_wdata
);
   import lmpf_pkg::*;

   // three plane banks: blue, green, red; address {row, group, y bit 2, x low}
   logic [LANE_W-1:0] bank_mem [PLANES][BANK_DEPTH];

   logic [NUM_BANDS-1:0][LANE_W-1:0] band_ff, band_in;

   logic               clr_busy_ff, clr_busy_in;
   logic [BANK_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // scan position: row, 48-word group, plane within group, word in plane
   logic [1:0] scan_row_ff, scan_row_in;
   logic [2:0] scan_grp_ff, scan_grp_in;
   logic [1:0] scan_pln_ff, scan_pln_in;
   logic [3:0] scan_low_ff, scan_low_in;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   // last write back, for the item whose read raced it
   logic                           fwd_valid_ff, fwd_valid_in;
   logic [BANK_AW-1:0]             fwd_addr_ff, fwd_addr_in;
   logic [PLANES-1:0][LANE_W-1:0]  fwd_data_ff, fwd_data_in;

   logic [PLANES-1:0][LANE_W-1:0]  rd_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                           req_accept;
   logic                           s1_adv;
   logic [BANK_AW-1:0]             rd_addr;
   logic                           mem_we;
   logic [BANK_AW-1:0]             mem_wa;
   logic [PLANES-1:0][LANE_W-1:0]  mem_wd;
   logic [PLANES-1:0][LANE_W-1:0]  cur_word;
   logic [PLANES-1:0][LANE_W-1:0]  new_word;
   logic [LANE_W-1:0]              mask;
   logic [2:0]                     get_color;
   logic                           idx_zero;
   logic                           scan_last;
   logic [1:0]                     row_next;

   // handshake and pipeline advance
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // scan sequencing, resolved when the item is accepted
   assign idx_zero  = (scan_grp_ff == 3'd0) && (scan_pln_ff == 2'd0) &&
                      (scan_low_ff == 4'd0);
   assign scan_last = (scan_grp_ff == 3'd7) && (scan_pln_ff == 2'd2) &&
                      (scan_low_ff == 4'd15);
   assign row_next  = idx_zero ? scan_row_ff + 2'd1 : scan_row_ff;

   always_comb begin
      scan_row_in = scan_row_ff;
      scan_grp_in = scan_grp_ff;
      scan_pln_in = scan_pln_ff;
      scan_low_in = scan_low_ff;
      s1_in       = s1_ff;
      rd_addr     = {req_data.pixel_y[1:0], req_data.pixel_x[5:3],
                     req_data.pixel_y[2], req_data.pixel_x[2:0]};
      if (req_data.opcode == OP_SCAN) begin
         rd_addr = {row_next, scan_grp_ff, scan_low_ff};
      end
      if (req_accept) begin
         s1_in.opcode = req_data.opcode;
         s1_in.color  = req_data.pixel_color;
         s1_in.band   = req_data.pixel_y[5:3];
         s1_in.addr   = rd_addr;
         s1_in.plane  = scan_pln_ff;
         s1_in.row    = row_next;
         s1_in.last   = scan_last;
         if (req_data.opcode == OP_SCAN) begin
            scan_row_in = row_next;
            scan_low_in = scan_low_ff + 4'd1;
            if (scan_low_ff == 4'd15) begin
               if (scan_pln_ff == 2'd2) begin
                  scan_pln_in = 2'd0;
                  scan_grp_in = scan_grp_ff + 3'd1;
               end else begin
                  scan_pln_in = scan_pln_ff + 2'd1;
               end
            end
         end
      end
   end

   // read data corrected by the write back that landed with the read
   assign mask = band_ff[s1_ff.band];

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         cur_word[p] = (fwd_valid_ff && (fwd_addr_ff == s1_ff.addr)) ?
                       fwd_data_ff[p] : rd_ff[p];
         new_word[p] = s1_ff.color[p] ? (cur_word[p] | mask) : (cur_word[p] & ~mask);
         get_color[p] = |(cur_word[p] & mask);
      end
   end

   // result formation
   always_comb begin
      rsp_in = '0;
      unique case (s1_ff.opcode)
         OP_GET: begin
            rsp_in.read_color = get_color;
         end
         OP_SCAN: begin
            unique case (s1_ff.plane)
               2'd0:    rsp_in.scan_word = cur_word[0];
               2'd1:    rsp_in.scan_word = cur_word[1];
               default: rsp_in.scan_word = cur_word[2];
            endcase
            rsp_in.row_address = s1_ff.row;
            rsp_in.last_in_row = s1_ff.last;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // bank write port: clearing pass, else set write back
   always_comb begin
      mem_we = clr_busy_ff || (s1_adv && (s1_ff.opcode == OP_SET));
      mem_wa = clr_busy_ff ? clr_cnt_ff : s1_ff.addr;
      mem_wd = clr_busy_ff ? '0 : new_word;
   end

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_valid_ff && rsp_stall);
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (req_accept) begin
         fwd_valid_in = s1_adv && (s1_ff.opcode == OP_SET);
         fwd_addr_in  = s1_ff.addr;
         fwd_data_in  = new_word;
      end
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == BANK_AW'(BANK_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      band_in = band_ff;
      if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_BANDS))) begin
         band_in[csr_index[2:0]] = csr_wdata;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff      <= BAND_RESET;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         scan_row_ff  <= '0;
         scan_grp_ff  <= '0;
         scan_pln_ff  <= '0;
         scan_low_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         band_ff      <= band_in;
         clr_busy_ff  <= clr_busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         scan_row_ff  <= scan_row_in;
         scan_grp_ff  <= scan_grp_in;
         scan_pln_ff  <= scan_pln_in;
         scan_low_ff  <= scan_low_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // plane banks, one write and one registered read each
   always_ff @(posedge clock) begin
      for (int p = 0; p < PLANES; p++) begin
         if (mem_we) begin
            bank_mem[p][mem_wa] <= mem_wd[p];
         end
         if (req_accept) begin
            rd_ff[p] <= bank_mem[p][rd_addr];
         end
      end
   end

   `ASSERT_NEVER(a_plane_range, scan_pln_ff == 2'd3, "scan plane counter out of range")
   `ASSERT_CLK(a_scan_wrap, (req_accept && (req_data.opcode == OP_SCAN) && scan_last) |=> idx_zero, "scan index did not wrap after last word")
   `ASSERT_CLK(a_clear_empty, clr_busy_ff |-> (!s1_valid_ff && !rsp_valid_ff), "item in flight during clearing pass")
   `ASSERT_CLK(a_hold_read, (s1_valid_ff && !s1_adv) |=> $stable(rd_ff), "bank read data lost while item held")

endmodule
